// ===== design/bitmap_frame_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap frame allocator
// Clocked, reset-gated property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication
`define BFA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bfa check failed");

// Next-cycle implication
`define BFA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bfa check failed");

`endif

// ===== design/bfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Sizes, codes and the command/status structs shared by the modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int FRAME_COUNT = 32768;
   localparam int WORD_BITS   = 64;
   localparam int PAGE_BYTES  = 4096;

   localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = $clog2(WORD_COUNT);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int PTR_W      = WADDR_W + 1;
   localparam int N_W        = WADDR_W + BIT_W;
   localparam int FRAME_W    = 15;
   localparam int ADDR_W     = 48;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PN_W       = ADDR_W - PAGE_SHIFT + 2;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_PAGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE = 3'd0,
      CSR_REGION_END  = 3'd1,
      CSR_KERNEL_LOW  = 3'd2,
      CSR_KERNEL_HIGH = 3'd3,
      CSR_BOOT_LOW    = 3'd4,
      CSR_BOOT_HIGH   = 3'd5
   } csr_idx_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_CLEAR, DP_LOAD, DP_FREE_RD, DP_FREE_WR, DP_SCAN, DP_BIT,
      DP_SIZE, DP_RANGE_K, DP_RANGE_B, DP_RANGE_CHK, DP_ORDER, DP_MERGE,
      DP_ADJ0, DP_ADJ1, DP_ADDR, DP_COMMIT
   } dp_op_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_FREE_RD, S_FREE_WR, S_SCAN, S_BIT, S_SIZE,
      S_RANGE_K, S_RANGE_B, S_RANGE_CHK, S_ORDER, S_MERGE, S_ADJ0, S_ADJ1,
      S_ADDR, S_CHECK, S_RESP
   } state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_grant;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_found;
      logic scan_empty;
      logic bit_found;
      logic page_bad;
   } dp_stat_type;

endpackage

// ===== design/bfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator datapath
// Config registers, bitmap RAM, scan counters, page arithmetic, result register.
// ----------------------------------------------------------------------------
module bfa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]     csr_write_data,
   input  logic [bfa_pkg::FRAME_W-1:0]    req_frame_index,
   input  bfa_pkg::dp_cmd_type            cmd,
   output bfa_pkg::dp_stat_type           stat,
   output logic [bfa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bfa_pkg::FRAME_W-1:0]    rsp_granted_index,
   output logic [bfa_pkg::ADDR_W-1:0]     rsp_frame_address
);

   localparam int AW = bfa_pkg::ADDR_W;
   localparam int PW = bfa_pkg::PN_W;
   localparam int WB = bfa_pkg::WORD_BITS;
   localparam int SH = bfa_pkg::PAGE_SHIFT;

   // configuration
   logic [AW-1:0] base_ff, end_ff, klo_ff, khi_ff, blo_ff, bhi_ff;

   // scan / request state
   logic [bfa_pkg::PTR_W-1:0]   word_ptr_ff, word_ptr_in;
   logic                        rd_pending_ff, rd_pending_in;
   logic [bfa_pkg::WADDR_W-1:0] rd_idx_ff;
   logic [bfa_pkg::WADDR_W-1:0] word_idx_ff;
   logic [WB-1:0]               word_ff;
   logic [bfa_pkg::BIT_W-1:0]   bit_ptr_ff, bit_ptr_in;
   logic [bfa_pkg::FRAME_W-1:0] idx_ff;

   // page arithmetic
   logic          no_pages_ff, kbad_ff;
   logic [PW-1:0] pages_ff, a0_ff, b0_ff, a1_ff, b1_ff, k_ff;
   logic          e0_ff, e1_ff;
   logic [AW-1:0] addr_ff;

   // result
   logic [bfa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bfa_pkg::FRAME_W-1:0]  rsp_index_ff;
   logic [AW-1:0]                rsp_addr_ff;

   // RAM port
   logic                        ram_we, ram_re;
   logic [bfa_pkg::WADDR_W-1:0] ram_waddr, ram_raddr;
   logic [WB-1:0]               ram_wdata, ram_rdata;

   logic [WB-1:0]               scan_word;
   logic                        scan_issue;
   logic [bfa_pkg::N_W-1:0]     n_val;
   logic [AW-1:0]               rng_lo, rng_hi;
   logic                        rng_pre;
   logic [PW-1:0]               rng_a, rng_b;
   logic [AW:0]                 lo_off;
   logic [PW+SH-1:0]            k_shift;
   logic                        bit_is_set;

   bfa_ram #(.WIDTH(WB), .DEPTH(bfa_pkg::WORD_COUNT)) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // bit 0 of word 0 is never granted: treat it as taken
   always_comb begin
      scan_word = ram_rdata;
      if (rd_idx_ff == '0) begin
         scan_word[0] = 1'b1;
      end
   end

   assign bit_is_set = word_ff[bit_ptr_ff] | ((word_idx_ff == '0) && (bit_ptr_ff == '0));
   assign n_val      = {word_idx_ff, bit_ptr_ff};
   assign scan_issue = (word_ptr_ff != bfa_pkg::PTR_W'(bfa_pkg::WORD_COUNT));

   assign stat.clear_done = (word_ptr_ff[bfa_pkg::WADDR_W-1:0] == '1);
   assign stat.scan_found = rd_pending_ff && !(&scan_word);
   assign stat.scan_empty = !scan_issue && !rd_pending_ff;
   assign stat.bit_found  = !bit_is_set;
   assign stat.page_bad   = no_pages_ff || kbad_ff || (addr_ff == '0);

   // exclusion range in page numbers, shared by both ranges
   always_comb begin
      rng_lo  = (cmd.op == bfa_pkg::DP_RANGE_B) ? blo_ff : klo_ff;
      rng_hi  = (cmd.op == bfa_pkg::DP_RANGE_B) ? bhi_ff : khi_ff;
      rng_pre = !(rng_hi < rng_lo) && !(rng_hi < base_ff);
      lo_off  = {1'b0, rng_lo - base_ff} + (AW+1)'(bfa_pkg::PAGE_BYTES - 1);
      rng_a   = (rng_lo <= base_ff) ? '0 : PW'(lo_off >> SH);
      rng_b   = PW'((rng_hi - base_ff) >> SH);
      k_shift = {k_ff, {SH{1'b0}}};
   end

   always_comb begin
      ram_we        = 1'b0;
      ram_waddr     = word_ptr_ff[bfa_pkg::WADDR_W-1:0];
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = word_ptr_ff[bfa_pkg::WADDR_W-1:0];
      word_ptr_in   = word_ptr_ff;
      rd_pending_in = rd_pending_ff;
      bit_ptr_in    = bit_ptr_ff;
      unique case (cmd.op)
         bfa_pkg::DP_CLEAR: begin
            ram_we      = 1'b1;
            word_ptr_in = word_ptr_ff + 1'b1;
         end
         bfa_pkg::DP_LOAD: begin
            word_ptr_in   = '0;
            rd_pending_in = 1'b0;
            bit_ptr_in    = '0;
         end
         bfa_pkg::DP_FREE_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff[bfa_pkg::FRAME_W-1 -: bfa_pkg::WADDR_W];
         end
         bfa_pkg::DP_FREE_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[bfa_pkg::FRAME_W-1 -: bfa_pkg::WADDR_W];
            ram_wdata = ram_rdata & ~(WB'(1) << idx_ff[bfa_pkg::BIT_W-1:0]);
         end
         bfa_pkg::DP_SCAN: begin
            ram_re        = scan_issue;
            rd_pending_in = scan_issue;
            if (scan_issue) begin
               word_ptr_in = word_ptr_ff + 1'b1;
            end
         end
         bfa_pkg::DP_BIT: begin
            if (bit_is_set) begin
               bit_ptr_in = bit_ptr_ff + 1'b1;
            end
         end
         bfa_pkg::DP_COMMIT: begin
            ram_we    = 1'b1;
            ram_waddr = word_idx_ff;
            ram_wdata = word_ff | (WB'(1) << bit_ptr_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         end_ff        <= '0;
         klo_ff        <= '0;
         khi_ff        <= '0;
         blo_ff        <= '0;
         bhi_ff        <= '0;
         word_ptr_ff   <= '0;
         rd_pending_ff <= 1'b0;
         bit_ptr_ff    <= '0;
      end else begin
         word_ptr_ff   <= word_ptr_in;
         rd_pending_ff <= rd_pending_in;
         bit_ptr_ff    <= bit_ptr_in;
         if (csr_write_enable) begin
            unique case (bfa_pkg::csr_idx_type'(csr_index))
               bfa_pkg::CSR_REGION_BASE: base_ff <= csr_write_data;
               bfa_pkg::CSR_REGION_END:  end_ff  <= csr_write_data;
               bfa_pkg::CSR_KERNEL_LOW:  klo_ff  <= csr_write_data;
               bfa_pkg::CSR_KERNEL_HIGH: khi_ff  <= csr_write_data;
               bfa_pkg::CSR_BOOT_LOW:    blo_ff  <= csr_write_data;
               bfa_pkg::CSR_BOOT_HIGH:   bhi_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_idx_ff <= ram_raddr;
      end
      unique case (cmd.op)
         bfa_pkg::DP_LOAD: begin
            idx_ff <= req_frame_index;
         end
         bfa_pkg::DP_SCAN: begin
            if (stat.scan_found) begin
               word_ff     <= ram_rdata;
               word_idx_ff <= rd_idx_ff;
            end
         end
         bfa_pkg::DP_SIZE: begin
            no_pages_ff <= ({1'b0, end_ff} <= ({1'b0, base_ff} + (AW+1)'(bfa_pkg::PAGE_BYTES)));
            pages_ff    <= PW'((end_ff - base_ff - 1'b1) >> SH);
         end
         bfa_pkg::DP_RANGE_K: begin
            a0_ff <= rng_a;
            b0_ff <= rng_b;
            e0_ff <= rng_pre;
         end
         bfa_pkg::DP_RANGE_B: begin
            a1_ff <= rng_a;
            b1_ff <= rng_b;
            e1_ff <= rng_pre;
         end
         bfa_pkg::DP_RANGE_CHK: begin
            e0_ff <= e0_ff && (a0_ff <= b0_ff);
            e1_ff <= e1_ff && (a1_ff <= b1_ff);
         end
         bfa_pkg::DP_ORDER: begin
            priority if (!e0_ff && e1_ff) begin
               a0_ff <= a1_ff;
               b0_ff <= b1_ff;
               e0_ff <= 1'b1;
               e1_ff <= 1'b0;
            end else if (e0_ff && e1_ff && (a1_ff < a0_ff)) begin
               a0_ff <= a1_ff;
               b0_ff <= b1_ff;
               a1_ff <= a0_ff;
               b1_ff <= b0_ff;
            end else begin
            end
         end
         bfa_pkg::DP_MERGE: begin
            if (e0_ff && e1_ff && (a1_ff <= b0_ff + 1'b1)) begin
               if (b1_ff > b0_ff) begin
                  b0_ff <= b1_ff;
               end
               e1_ff <= 1'b0;
            end
         end
         bfa_pkg::DP_ADJ0: begin
            if (e0_ff && (PW'(n_val) >= a0_ff)) begin
               k_ff <= PW'(n_val) + (b0_ff - a0_ff + 1'b1);
            end else begin
               k_ff <= PW'(n_val);
            end
         end
         bfa_pkg::DP_ADJ1: begin
            if (e1_ff && (k_ff >= a1_ff)) begin
               k_ff <= k_ff + (b1_ff - a1_ff + 1'b1);
            end
         end
         bfa_pkg::DP_ADDR: begin
            kbad_ff <= (k_ff >= pages_ff);
            addr_ff <= base_ff + k_shift[AW-1:0];
         end
         default: begin
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_index_ff  <= cmd.rsp_grant ? bfa_pkg::FRAME_W'(n_val) : '0;
         rsp_addr_ff   <= cmd.rsp_grant ? addr_ff : '0;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_frame_address = rsp_addr_ff;

endmodule

// ===== design/bfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequences clear, free, scan and page mapping; owns the result valid.
// ----------------------------------------------------------------------------
module bfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bfa_pkg::dp_stat_type stat,
   output bfa_pkg::dp_cmd_type  cmd
);

   bfa_pkg::state_type  state_ff, state_in;
   bfa_pkg::status_type status_ff, status_in;
   logic                grant_ff, grant_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::S_CLEAR;
         status_ff    <= bfa_pkg::ST_OK;
         grant_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         grant_ff     <= grant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      grant_in       = grant_ff;
      cmd.op         = bfa_pkg::DP_NOP;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = status_ff;
      cmd.rsp_grant  = grant_ff;
      req_stall      = (state_ff != bfa_pkg::S_IDLE);
      unique case (state_ff)
         bfa_pkg::S_CLEAR: begin
            cmd.op = bfa_pkg::DP_CLEAR;
            if (stat.clear_done) begin
               state_in = bfa_pkg::S_IDLE;
            end
         end
         bfa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op    = bfa_pkg::DP_LOAD;
               status_in = bfa_pkg::ST_OK;
               grant_in  = 1'b0;
               state_in  = (bfa_pkg::op_type'(req_operation) == bfa_pkg::OP_FREE)
                           ? bfa_pkg::S_FREE_RD : bfa_pkg::S_SCAN;
            end
         end
         bfa_pkg::S_FREE_RD: begin
            cmd.op   = bfa_pkg::DP_FREE_RD;
            state_in = bfa_pkg::S_FREE_WR;
         end
         bfa_pkg::S_FREE_WR: begin
            cmd.op   = bfa_pkg::DP_FREE_WR;
            state_in = bfa_pkg::S_RESP;
         end
         bfa_pkg::S_SCAN: begin
            cmd.op = bfa_pkg::DP_SCAN;
            priority if (stat.scan_found) begin
               state_in = bfa_pkg::S_BIT;
            end else if (stat.scan_empty) begin
               status_in = bfa_pkg::ST_FULL;
               state_in  = bfa_pkg::S_RESP;
            end else begin
            end
         end
         bfa_pkg::S_BIT: begin
            cmd.op = bfa_pkg::DP_BIT;
            if (stat.bit_found) begin
               state_in = bfa_pkg::S_SIZE;
            end
         end
         bfa_pkg::S_SIZE: begin
            cmd.op   = bfa_pkg::DP_SIZE;
            state_in = bfa_pkg::S_RANGE_K;
         end
         bfa_pkg::S_RANGE_K: begin
            cmd.op   = bfa_pkg::DP_RANGE_K;
            state_in = bfa_pkg::S_RANGE_B;
         end
         bfa_pkg::S_RANGE_B: begin
            cmd.op   = bfa_pkg::DP_RANGE_B;
            state_in = bfa_pkg::S_RANGE_CHK;
         end
         bfa_pkg::S_RANGE_CHK: begin
            cmd.op   = bfa_pkg::DP_RANGE_CHK;
            state_in = bfa_pkg::S_ORDER;
         end
         bfa_pkg::S_ORDER: begin
            cmd.op   = bfa_pkg::DP_ORDER;
            state_in = bfa_pkg::S_MERGE;
         end
         bfa_pkg::S_MERGE: begin
            cmd.op   = bfa_pkg::DP_MERGE;
            state_in = bfa_pkg::S_ADJ0;
         end
         bfa_pkg::S_ADJ0: begin
            cmd.op   = bfa_pkg::DP_ADJ0;
            state_in = bfa_pkg::S_ADJ1;
         end
         bfa_pkg::S_ADJ1: begin
            cmd.op   = bfa_pkg::DP_ADJ1;
            state_in = bfa_pkg::S_ADDR;
         end
         bfa_pkg::S_ADDR: begin
            cmd.op   = bfa_pkg::DP_ADDR;
            state_in = bfa_pkg::S_CHECK;
         end
         bfa_pkg::S_CHECK: begin
            if (stat.page_bad) begin
               status_in = bfa_pkg::ST_NO_PAGE;
            end else begin
               cmd.op   = bfa_pkg::DP_COMMIT;
               grant_in = 1'b1;
            end
            state_in = bfa_pkg::S_RESP;
         end
         bfa_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = bfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/bitmap_frame_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator, top level
// Controller plus datapath around a 512 x 64 bitmap RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM to zero, one word per cycle,
// and holds req_stall high meanwhile (csr writes are taken at any time).
// One item is worked at a time. A free reads the bitmap word, writes it
// back with the bit cleared, then hands off the result. An allocate scans
// the bitmap one word per cycle through the RAM read port until it meets a
// word with a clear bit (else it reports full), steps through that word one
// bit per cycle, then maps the frame index to a page address through the
// size, range, order, merge, adjust and address states. The RAM read port
// and the bit-serial search dominate. A finished result sits in the output
// register while the next item is taken; csr writes belong to idle periods.

module bitmap_frame_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [bfa_pkg::FRAME_W-1:0]   req_frame_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bfa_pkg::FRAME_W-1:0]   rsp_granted_index,
   output logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_address
);

   bfa_pkg::dp_cmd_type  cmd;
   bfa_pkg::dp_stat_type stat;

   // sequence each item
   bfa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   // hold config, bitmap and page arithmetic
   bfa_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_frame_index   (req_frame_index),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_frame_address (rsp_frame_address)
   );

endmodule

// ===== design/bfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_top_assert.svh"

module bfa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bfa_pkg::FRAME_W-1:0]   rsp_granted_index,
   input logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_address
);

   // a stalled result stays
   `BFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // one item at a time: busy right after an accept
   `BFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // failures carry no grant
   `BFA_ASSERT_NOW(a_fail_zero, clock, reset,
      rsp_valid && (rsp_status != bfa_pkg::ST_OK),
      (rsp_granted_index == '0) && (rsp_frame_address == '0))

   // a granted page never comes from index zero
   `BFA_ASSERT_NOW(a_grant_index, clock, reset,
      rsp_valid && (rsp_frame_address != '0),
      (rsp_granted_index != '0) && (rsp_status == bfa_pkg::ST_OK))

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_granted_index (rsp_granted_index),
   .rsp_frame_address (rsp_frame_address)
);
